### hdl/urlpd_pkg.sv
// urlpd_pkg: shared types, character constants and hex helpers for the
// URL percent decoder. No dependencies.
`default_nettype none

package urlpd_pkg;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  localparam int unsigned MaxBeats = 3;
  localparam int unsigned CntW     = $clog2(MaxBeats + 1);
  localparam int unsigned IdxW     = $clog2(MaxBeats);

  // APB register map (byte addresses)
  localparam int unsigned    PaddrW       = 3;
  localparam logic [PaddrW-1:0] ADDR_DECODE_AMP = 3'h0;

  // Result group of one input beat: up to three output bytes, byte 0 first.
  typedef struct packed {
    logic [CntW-1:0]           cnt;
    logic [MaxBeats-1:0][7:0]  bytes;
  } grp_t;

  // Hex digit value; bit 4 flags a valid digit.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c inside {CH_SPACE, [8'h09:8'h0D]};
  endfunction

  // Two-byte escape value, as strtoul base 16 reads it, cut to 8 bits.
  function automatic logic [7:0] escape_value(input logic [7:0] a,
                                              input logic [7:0] b);
    logic [4:0] ha;
    logic [4:0] hb;
    logic [7:0] v;
    ha = hex_digit(a);
    hb = hex_digit(b);
    v  = 8'd0;
    if (is_blank(a) || a == CH_PLUS) begin
      if (hb[4]) v = {4'd0, hb[3:0]};
    end else if (a == CH_MINUS) begin
      if (hb[4]) v = 8'(8'd0 - {4'd0, hb[3:0]});
    end else if (ha[4]) begin
      v = hb[4] ? {ha[3:0], hb[3:0]} : {4'd0, ha[3:0]};
    end
    return v;
  endfunction

endpackage

`default_nettype wire

### hdl/urlpd_regs.sv
// urlpd_regs: APB-style configuration register (decode_ampersand).
// Depends on urlpd_pkg.
`default_nettype none

module urlpd_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [urlpd_pkg::PaddrW-1:0]  paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready,
  output logic                               decode_ampersand
);
  import urlpd_pkg::*;

  logic hit;
  logic wr;

  assign hit    = (paddr == ADDR_DECODE_AMP);
  assign wr     = psel && penable && pwrite && hit;
  assign pready = 1'b1;
  assign prdata = hit ? {31'd0, decode_ampersand} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      decode_ampersand <= 1'b1;
    end else if (wr) begin
      decode_ampersand <= pwdata[0];
    end
  end

endmodule

`default_nettype wire

### hdl/urlpd_decode.sv
// urlpd_decode: escape state machine and per-beat decode into a result group.
// Depends on urlpd_pkg.
`default_nettype none

module urlpd_decode (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 accept,
  input  wire logic [7:0]           in_byte,
  input  wire logic                 decode_ampersand,
  output urlpd_pkg::grp_t           grp
);
  import urlpd_pkg::*;

  localparam logic [1:0] PH_TEXT   = 2'd0;
  localparam logic [1:0] PH_FIRST  = 2'd1;
  localparam logic [1:0] PH_SECOND = 2'd2;

  logic [1:0] phase, phase_next;
  logic [7:0] first_char, first_char_next;
  logic       muted, muted_next;
  logic [7:0] esc_val;

  assign esc_val = escape_value(first_char, in_byte);

  always_comb begin
    phase_next      = phase;
    first_char_next = first_char;
    muted_next      = muted;
    grp             = '0;
    if (in_byte == CH_NUL) begin
      phase_next      = PH_TEXT;
      first_char_next = 8'd0;
      muted_next      = 1'b0;
      grp.cnt         = CntW'(1);
      grp.bytes[0]    = CH_NUL;
    end else if (!muted) begin
      case (phase)
        PH_FIRST: begin
          first_char_next = in_byte;
          phase_next      = PH_SECOND;
        end
        PH_SECOND: begin
          phase_next      = PH_TEXT;
          first_char_next = 8'd0;
          if (!decode_ampersand && esc_val == CH_AMP) begin
            // keep the original three bytes
            grp.cnt      = CntW'(3);
            grp.bytes[0] = CH_PCT;
            grp.bytes[1] = first_char;
            grp.bytes[2] = in_byte;
          end else if (esc_val == 8'd0) begin
            muted_next = 1'b1;
          end else begin
            grp.cnt      = CntW'(1);
            grp.bytes[0] = esc_val;
          end
        end
        default: begin
          if (in_byte == CH_PCT) begin
            phase_next = PH_FIRST;
          end else begin
            grp.cnt      = CntW'(1);
            grp.bytes[0] = (in_byte == CH_PLUS) ? CH_SPACE : in_byte;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_TEXT;
      first_char <= 8'd0;
      muted      <= 1'b0;
    end else if (accept) begin
      phase      <= phase_next;
      first_char <= first_char_next;
      muted      <= muted_next;
    end
  end

endmodule

`default_nettype wire

### hdl/urlpd_outq.sv
// urlpd_outq: two-slot result-group buffer that serializes groups into beats.
// Depends on urlpd_pkg.
`default_nettype none

module urlpd_outq (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire urlpd_pkg::grp_t grp,
  output logic                 can_push,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [7:0]           out_byte,
  output logic                 last_of_run
);
  import urlpd_pkg::*;

  grp_t            cur;
  grp_t            pend;
  logic            cur_valid;
  logic            pend_valid;
  logic [IdxW-1:0] idx;
  logic            beat_taken;
  logic            cur_free;

  assign can_push    = !pend_valid;
  assign out_valid   = cur_valid;
  assign out_byte    = cur.bytes[idx];
  assign last_of_run = (CntW'(idx) == CntW'(cur.cnt - CntW'(1)));
  assign beat_taken  = cur_valid && out_ready;
  // slot frees when empty or its final beat goes out now
  assign cur_free    = !cur_valid || (beat_taken && last_of_run);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid  <= 1'b0;
      pend_valid <= 1'b0;
      idx        <= '0;
    end else if (cur_free) begin
      idx <= '0;
      if (pend_valid) begin
        cur_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else begin
        cur_valid <= push;
      end
    end else begin
      if (beat_taken) idx <= IdxW'(idx + IdxW'(1));
      if (push) pend_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cur_free) begin
      cur <= pend_valid ? pend : grp;
    end else if (push) begin
      pend <= grp;
    end
  end

endmodule

`default_nettype wire

### hdl/url_percent_decoder_core.sv
// url_percent_decoder_core: top level of the URL percent decoder.
// Depends on urlpd_pkg, urlpd_regs, urlpd_decode, urlpd_outq.
//
//  channel | signals                                      | beat
//  --------+----------------------------------------------+--------------------------
//  input   | in_valid, in_ready, in_byte                  | one fragment byte
//  output  | out_valid, out_ready, out_byte, last_of_run  | one decoded byte
//  config  | psel, penable, pwrite, paddr, pwdata, prdata | decode_ampersand at 0x0
//
// Cycles: an input beat is decoded in the cycle it is accepted and its
// result group (0 to 3 bytes) lands in the output buffer at that edge.
// Input runs 1 beat per cycle while in_ready is high; sustained output is
// 1 beat per cycle while out_ready is high, so a beat that keeps all three
// escape bytes is sent as three output beats.
// Stalls: the buffer holds the group being sent plus one waiting group, so
// input is still taken while a result sits unclaimed; in_ready drops only
// once the waiting slot is full.
// Reset: synchronous rst clears escape state, mute flag and buffer, and sets
// decode_ampersand to 1.
`default_nettype none

module url_percent_decoder_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // input beats
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [7:0]                    in_byte,
  // output beats
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [7:0]                         out_byte,
  output logic                               last_of_run,
  // configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [urlpd_pkg::PaddrW-1:0]  paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready
);
  import urlpd_pkg::*;

  logic decode_ampersand;
  logic in_accept;
  grp_t grp;

  assign in_accept = in_valid && in_ready;

  urlpd_regs u_regs (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .decode_ampersand (decode_ampersand)
  );

  // decode logic sees the raw input byte and the stored escape state
  urlpd_decode u_decode (
    .clk              (clk),
    .rst              (rst),
    .accept           (in_accept),
    .in_byte          (in_byte),
    .decode_ampersand (decode_ampersand),
    .grp              (grp)
  );

  // silent beats (muted, escape start, first escape byte, zero escape) push nothing
  urlpd_outq u_outq (
    .clk         (clk),
    .rst         (rst),
    .push        (in_accept && (grp.cnt != '0)),
    .grp         (grp),
    .can_push    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

endmodule

`default_nettype wire

### hdl/urlpd_checker.sv
// urlpd_checker: port-level assertions for url_percent_decoder_core, and
// the bind that attaches them. Depends on url_percent_decoder_core's ports.
`default_nettype none

module urlpd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       last_of_run,
  input wire logic       pready
);

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last_of_run))
    else $error("output beat changed while stalled");

  // nothing pending right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // a zero byte only comes from the terminator, always a single beat
  a_zero_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_byte == 8'd0 |-> last_of_run)
    else $error("zero byte not marked last");

  // input backpressure only while output is holding a beat
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |-> out_valid)
    else $error("input stalled with empty output");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind url_percent_decoder_core urlpd_checker u_urlpd_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_byte    (out_byte),
  .last_of_run (last_of_run),
  .pready      (pready)
);

`default_nettype wire

### tb/url_percent_decoder_core_test.sv
// url_percent_decoder_core_test: self-checking testbench for url_percent_decoder_core.
// Drives bytes, config writes and output stalls, predicts each decoded beat and checks it.
// Depends on urlpd_pkg and url_percent_decoder_core.

module url_percent_decoder_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import urlpd_pkg::*;

  localparam int unsigned MaxCycles = 300000;

  // A few more characters for the escape stimulus.
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_LOW_X = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // One decoded byte as the output channel should carry it.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_beat_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and block inputs; every input holds a known value from time 0.
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        in_valid  = 1'b0;
  logic [7:0]  in_byte   = 8'h00;
  logic        out_ready = 1'b0;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [PaddrW-1:0] paddr = '0;
  logic [31:0] pwdata    = 32'h0;

  logic        in_ready;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic        last_of_run;
  logic [31:0] prdata;
  logic        pready;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  url_percent_decoder_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // ---------------------------------------------------------------------------
  // Decoder shadow: mirrors the block's escape state and its config bit.
  // Reset values match the block after rst.
  // ---------------------------------------------------------------------------
  logic       amp_decode_on = 1'b1;  // shadow of decode_ampersand
  logic [1:0] esc_phase     = 2'd0;  // 0 text, 1 want first digit, 2 want second
  logic [7:0] esc_first     = 8'h00;
  logic       silenced      = 1'b0;  // a decoded zero mutes until the terminator

  out_beat_t  decoded_q[$];          // beats still owed by the block
  out_beat_t  owed;
  int         error_count = 0;
  int         cycle_count = 0;
  int         bytes_sent  = 0;
  int         burst_left  = 0;

  // Hex value of an ASCII digit, -1 when it is not one.
  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
    return -1;
  endfunction

  function automatic logic is_space_char(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  // Two escape bytes read the way strtoul(.., 16) reads them, kept to 8 bits:
  // leading blank or sign, then digits up to the first non-hex byte.
  function automatic logic [7:0] strtoul_byte(input logic [7:0] a, input logic [7:0] b);
    int ha;
    int hb;
    ha = hex_nibble(a);
    hb = hex_nibble(b);
    if (is_space_char(a) || a == CH_PLUS) return (hb >= 0) ? 8'(hb) : 8'h00;
    if (a == CH_MINUS)                    return (hb >= 0) ? 8'(256 - hb) : 8'h00;
    if (ha >= 0)                          return (hb >= 0) ? 8'(ha * 16 + hb) : 8'(ha);
    return 8'h00;
  endfunction

  function automatic void push_beat(input logic [7:0] d, input logic last);
    out_beat_t b;
    b.data = d;
    b.last = last;
    decoded_q.push_back(b);
  endfunction

  // Advance the shadow by one accepted input byte and queue what it yields.
  function automatic void decode_step(input logic [7:0] c);
    logic [7:0] v;
    if (c == CH_NUL) begin
      esc_phase = 2'd0;
      esc_first = 8'h00;
      silenced  = 1'b0;
      push_beat(CH_NUL, 1'b1);
    end else if (silenced) begin
      // swallowed until the terminator
    end else if (esc_phase == 2'd1) begin
      esc_first = c;
      esc_phase = 2'd2;
    end else if (esc_phase == 2'd2) begin
      v = strtoul_byte(esc_first, c);
      esc_phase = 2'd0;
      if (!amp_decode_on && v == CH_AMP) begin
        // ampersand kept in its escaped form
        push_beat(CH_PCT, 1'b0);
        push_beat(esc_first, 1'b0);
        push_beat(c, 1'b1);
      end else if (v == 8'h00) begin
        silenced = 1'b1;
      end else begin
        push_beat(v, 1'b1);
      end
      esc_first = 8'h00;
    end else if (c == CH_PCT) begin
      esc_phase = 2'd1;
    end else if (c == CH_PLUS) begin
      push_beat(CH_SPACE, 1'b1);
    end else begin
      push_beat(c, 1'b1);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("MISMATCH %s: got %02h want %02h at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Beat monitor. Values are sampled at the edge, before the NBAs of that
  // edge land, so both channels see what was present when the beat moved.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          report_mismatch("unexpected output beat", out_byte, 8'h00);
        end else begin
          owed = decoded_q.pop_front();
          if (out_byte !== owed.data)
            report_mismatch("out_byte", out_byte, owed.data);
          if (last_of_run !== owed.last)
            report_mismatch("last_of_run", {7'd0, last_of_run}, {7'd0, owed.last});
        end
      end
      if (in_valid && in_ready) decode_step(in_byte);
    end
  end

  // Receiver: out_ready steps through a 16-bit ready pattern that is swapped
  // periodically. Patterns run from always-ready to one beat in sixteen.
  logic [15:0] ready_pat = 16'hFFFF;
  int          pat_pos   = 0;
  int          pat_age   = 0;

  always @(posedge clk) begin
    if (pat_age == 0) begin
      case ($urandom_range(0, 4))
        0:       ready_pat = 16'hFFFF;
        1:       ready_pat = 16'h0001;
        2:       ready_pat = 16'hAAAA;
        default: ready_pat = 16'($urandom) | 16'h0001;
      endcase
      pat_age = 64;
    end
    pat_age--;
    pat_pos = (pat_pos + 1) % 16;
    out_ready <= ready_pat[pat_pos];
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MaxCycles) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycle_count,
               decoded_q.size());
      $display("url_percent_decoder_core_test: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Bursts of 1..24 beats; between bursts, usually a random gap with in_valid low.
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  // One input beat. valid stays up afterwards so back-to-back beats never
  // drop it; pace() or drain() lowers it.
  task automatic send_byte(input logic [7:0] b);
    pace();
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Stop sending until every owed beat is out, then let the pipeline settle.
  // The first edge lets the monitor log the last accepted beat.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write then read-back of decode_ampersand; only bit 0 is defined.
  task automatic set_amp_decode(input logic on);
    logic [31:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_DECODE_AMP;
    pwdata  <= {$urandom_range(0, 1) ? 31'($urandom) : 31'd0, on};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    amp_decode_on = on;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (rd[0] !== on) report_mismatch("decode_ampersand readback", {7'd0, rd[0]}, {7'd0, on});
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v, input logic upper);
    if (v < 4'd10) return 8'h30 + 8'(v);
    return upper ? 8'h37 + 8'(v) : 8'h57 + 8'(v);
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Plain bytes at the range ends and '+' to space.
  task automatic test_pass_through();
    send_byte(8'hFF);
    send_byte(8'h01);
    send_byte(CH_PLUS);
  endtask

  // Whitespace lead, minus sign, digit then non-digit, full hex pair.
  task automatic test_escapes();
    send_text("%\tF");
    send_text("%-1");
    send_text("%A!");
    send_text("%26");
    send_byte(CH_NUL);
  endtask

  // "0x" decodes to zero: output goes quiet until the terminator.
  task automatic test_mute();
    send_text("%0xq");
    send_byte(CH_NUL);
  endtask

  // Escape cut short by the terminator is dropped.
  task automatic test_unfinished_escape();
    send_text("%4");
    send_byte(CH_NUL);
  endtask

  // With ampersand decode off, %26 comes back as its three bytes.
  task automatic test_ampersand_off();
    drain();
    set_amp_decode(1'b0);
    send_text("%26a");
    send_byte(CH_NUL);
    drain();
    set_amp_decode(1'b1);
  endtask

  // Random fragments, mostly well formed: plain bytes, '+', hex escapes,
  // escapes with odd leads, and some raw noise. Four config phases.
  task automatic test_random_traffic();
    int         frag;
    int         toks;
    int         phase_start;
    logic [7:0] a;
    logic [7:0] b;
    frag = 0;
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      set_amp_decode(ph[0]);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < 100) begin
        toks = $urandom_range(1, 12);
        repeat (toks) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
              do b = 8'($urandom_range(1, 255)); while (b == CH_PCT);
              send_byte(b);
            end
            4: send_byte(CH_PLUS);
            5, 6: begin
              send_byte(CH_PCT);
              send_byte(hex_char(4'($urandom), 1'($urandom)));
              send_byte(hex_char(4'($urandom), 1'($urandom)));
            end
            7: send_text("%26");
            8: begin
              b = 8'h00;
              case ($urandom_range(0, 5))
                0: a = CH_SPACE;
                1: a = 8'($urandom_range(CH_TAB, CH_CR));
                2: a = CH_PLUS;
                3: a = CH_MINUS;
                4: begin
                  a = CH_ZERO;
                  b = $urandom_range(0, 1) ? CH_LOW_X : CH_UP_X;
                end
                default: a = 8'($urandom_range(1, 255));
              endcase
              if (b == 8'h00)
                b = $urandom_range(0, 1) ? hex_char(4'($urandom), 1'($urandom))
                                         : 8'($urandom_range(1, 255));
              send_byte(CH_PCT);
              send_byte(a);
              send_byte(b);
            end
            default: send_byte(8'($urandom_range(1, 255)));
          endcase
        end
        // occasionally leave an escape open at the terminator
        if ($urandom_range(0, 7) == 0) begin
          send_byte(CH_PCT);
          if ($urandom_range(0, 1)) send_byte(hex_char(4'($urandom), 1'($urandom)));
        end
        send_byte(CH_NUL);
        frag++;
        // let the output side catch up completely now and then
        if (frag % 6 == 3) drain();
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_pass_through();
    test_escapes();
    test_mute();
    test_unfinished_escape();
    test_ampersand_off();
    test_random_traffic();

    in_valid <= 1'b0;
    @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("url_percent_decoder_core_test: done, clean");
    end else begin
      $display("url_percent_decoder_core_test: done, errors");
    end
    $finish;
  end

endmodule
